@@ src/wgm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants of the wildcard glob matcher: request kinds,
// request structs, wildcard characters and the default pattern capacity.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    typedef enum logic [1:0] {
        KIND_PAT_BYTE  = 2'd0,
        KIND_PAT_END   = 2'd1,
        KIND_CAND_BYTE = 2'd2,
        KIND_CAND_END  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
    } t_in_req;

    typedef struct packed {
        logic matched;
        logic pattern_error;
    } t_out_req;

    typedef struct packed {
        logic restart;
        logic advance;
    } t_act_cmd;

endpackage

@@ src/wildcard_glob_matcher_unit.sv @@
// a candidate end passes the input register, then the result register; a stalled result holds it in the input register
// throughput: one request per cycle, every kind, while results are not stalled, set by the single active-set update
// the active set update is one carry chain over the pattern positions plus compares
// reset: synchronous active low, empty pattern stored and closed, no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// Whole-string glob matcher with star and question mark wildcards. Input
// register, pattern store, active position set and result register.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wgm_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output wgm_pkg::t_out_req o_out_req
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic                        r_in_vld;
    logic                        n_in_vld;
    wgm_pkg::t_in_req            r_in;
    logic                        r_out_vld;
    logic                        n_out_vld;
    wgm_pkg::t_out_req           r_out;
    wgm_pkg::t_out_req           n_out;
    logic                        accept;
    logic                        step_go;
    logic                        load;
    logic                        close;
    logic                        emit;
    wgm_pkg::t_act_cmd           act_cmd;
    logic [LW-1:0]               pat_len;
    logic                        pat_closed;
    logic                        pat_ovf;
    logic [MAX_PATTERN-1:0][7:0] pat_bytes;
    logic                        hit;

    assign step_go    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !step_go;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        load            = 1'b0;
        close           = 1'b0;
        emit            = 1'b0;
        act_cmd.restart = 1'b0;
        act_cmd.advance = 1'b0;
        if (step_go) begin
            case (r_in.kind)
                wgm_pkg::KIND_PAT_BYTE: begin
                    load            = 1'b1;
                    act_cmd.restart = 1'b1;
                end
                wgm_pkg::KIND_PAT_END: begin
                    close           = 1'b1;
                    act_cmd.restart = 1'b1;
                end
                wgm_pkg::KIND_CAND_BYTE: begin
                    act_cmd.advance = pat_closed;
                end
                wgm_pkg::KIND_CAND_END: begin
                    emit            = pat_closed;
                    act_cmd.restart = pat_closed;
                end
                default: begin
                    load = 1'b0;
                end
            endcase
        end
    end

    wgm_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_close    (close),
        .i_byte     (r_in.byte_value),
        .o_len      (pat_len),
        .o_closed   (pat_closed),
        .o_overflow (pat_ovf),
        .o_bytes    (pat_bytes)
    );

    wgm_active_set #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_active (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (act_cmd),
        .i_byte  (r_in.byte_value),
        .i_len   (pat_len),
        .i_bytes (pat_bytes),
        .o_hit   (hit)
    );

    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (step_go) begin
            n_in_vld = 1'b0;
        end
        if (emit) begin
            n_out_vld           = 1'b1;
            n_out.matched       = hit && !pat_ovf;
            n_out.pattern_error = pat_ovf;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_req;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

`ifndef SYNTHESIS
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid)
        else $error("candidate end produced no result");

    a_error_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_req.matched && o_out_req.pattern_error))
        else $error("match reported on an overflowed pattern");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pat_ovf |-> (pat_len == LW'(MAX_PATTERN)))
        else $error("overflow flagged below capacity");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("stalled result changed");
`endif

endmodule

@@ src/wgm_pattern_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pattern_store
// Holds the glob pattern bytes, its length, the closed flag and the
// overflow flag. Each position is a register of its own, read in parallel.
// ----------------------------------------------------------------------------
module wgm_pattern_store #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_close,
    input  logic [7:0]                  i_byte,
    output logic [LW-1:0]               o_len,
    output logic                        o_closed,
    output logic                        o_overflow,
    output logic [MAX_PATTERN-1:0][7:0] o_bytes
);

    localparam logic [LW-1:0] MaxLen = LW'(MAX_PATTERN);

    logic [MAX_PATTERN-1:0][7:0] r_bytes;
    logic [LW-1:0]               r_len;
    logic [LW-1:0]               n_len;
    logic                        r_closed;
    logic                        n_closed;
    logic                        r_overflow;
    logic                        n_overflow;
    logic [LW-1:0]               base_len;
    logic                        base_ovf;
    logic                        full;

    // a byte arriving on a closed pattern starts a new one
    assign base_len = r_closed ? '0 : r_len;
    assign base_ovf = r_closed ? 1'b0 : r_overflow;
    assign full     = (base_len == MaxLen);

    always_comb begin
        n_len      = r_len;
        n_closed   = r_closed;
        n_overflow = r_overflow;
        if (i_load) begin
            n_closed = 1'b0;
            if (full) begin
                n_len      = base_len;
                n_overflow = 1'b1;
            end else begin
                n_len      = base_len + LW'(1);
                n_overflow = base_ovf;
            end
        end else if (i_close) begin
            n_closed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_closed   <= 1'b1;
            r_overflow <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_closed   <= n_closed;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i_load && !full && (base_len == LW'(i))) begin
                r_bytes[i] <= i_byte;
            end
        end
    end

    assign o_len      = r_len;
    assign o_closed   = r_closed;
    assign o_overflow = r_overflow;
    assign o_bytes    = r_bytes;

endmodule

@@ src/wgm_active_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_active_set
// Keeps the set of reachable pattern positions. Star closure is a carry
// chain over the star mask; one candidate byte advances every position.
// ----------------------------------------------------------------------------
module wgm_active_set #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wgm_pkg::t_act_cmd           i_cmd,
    input  logic [7:0]                  i_byte,
    input  logic [LW-1:0]               i_len,
    input  logic [MAX_PATTERN-1:0][7:0] i_bytes,
    output logic                        o_hit
);

    logic [MAX_PATTERN:0]   r_raw;
    logic [MAX_PATTERN:0]   n_raw;
    logic [MAX_PATTERN:0]   star_mask;
    logic [MAX_PATTERN:0]   gen;
    logic [MAX_PATTERN:0]   sum;
    logic [MAX_PATTERN:0]   closed;
    logic [MAX_PATTERN-1:0] keep;
    logic [MAX_PATTERN-1:0] step;

    always_comb begin
        star_mask = '0;
        keep      = '0;
        step      = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            star_mask[i] = (LW'(i) < i_len) && (i_bytes[i] == wgm_pkg::STAR_CHAR);
        end
        gen    = r_raw & star_mask;
        sum    = gen + star_mask;
        closed = r_raw | (sum ^ star_mask ^ gen);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            keep[i] = closed[i] && star_mask[i];
            step[i] = closed[i] && (LW'(i) < i_len) && !star_mask[i]
                      && ((i_bytes[i] == wgm_pkg::ANY_CHAR) || (i_bytes[i] == i_byte));
        end
    end

    always_comb begin
        n_raw = r_raw;
        if (i_cmd.restart) begin
            n_raw = (MAX_PATTERN + 1)'(1);
        end else if (i_cmd.advance) begin
            n_raw = {1'b0, keep} | {step, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= (MAX_PATTERN + 1)'(1);
        end else begin
            r_raw <= n_raw;
        end
    end

    assign o_hit = closed[i_len];

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the wildcard glob matcher unit. Pattern and candidate requests come
// from a queue: first a directed run, then random sessions. Each session
// loads a pattern (mostly short, some over capacity) and streams names,
// most built from it, some altered. Both sides idle in random bursts. A
// predictor tracks pattern and live positions and scores results in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_PATTERN    = wgm_pkg::MAX_PATTERN_DEF;
    localparam int ITEMS          = 1500;
    localparam int QUIET_TAIL     = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_CAP      = 200;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    wgm_pkg::t_in_req  in_req    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    wgm_pkg::t_out_req out_req;

    wgm_pkg::t_in_req  pending_reqs[$];
    wgm_pkg::t_out_req expected_results[$];
    wgm_pkg::t_out_req want_result;

    logic [7:0]           glob_pat[MAX_PATTERN];
    int unsigned          glob_len;
    bit                   glob_closed;
    bit                   glob_ovf;
    bit [MAX_PATTERN:0]   live_pos;

    int mismatches     = 0;
    int quiet_cycles   = 0;
    int accepted_count = 0;
    int total_items    = 0;
    int in_gap         = 0;
    int in_calm        = 0;
    int out_gap        = 0;
    int out_calm       = 0;

    wildcard_glob_matcher_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    function automatic void push_req(input wgm_pkg::t_kind kind, input logic [7:0] ch);
        wgm_pkg::t_in_req req;
        req.kind       = kind;
        req.byte_value = ch;
        pending_reqs.push_back(req);
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return "a";
            4, 5, 6, 7: return "b";
            8:          return wgm_pkg::STAR_CHAR;
            default:    return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // star positions also reach the next position
    function automatic void spread_stars();
        for (int i = 0; i < glob_len; i++) begin
            if (live_pos[i] && glob_pat[i] == wgm_pkg::STAR_CHAR) begin
                live_pos[i + 1] = 1'b1;
            end
        end
    endfunction

    function automatic void rewind_candidate();
        live_pos    = '0;
        live_pos[0] = 1'b1;
        spread_stars();
    endfunction

    function automatic void step_candidate(input logic [7:0] ch);
        bit [MAX_PATTERN:0] nxt;
        nxt = '0;
        for (int i = 0; i < glob_len; i++) begin
            if (live_pos[i]) begin
                if (glob_pat[i] == wgm_pkg::STAR_CHAR) begin
                    nxt[i] = 1'b1;
                end else if (glob_pat[i] == wgm_pkg::ANY_CHAR || glob_pat[i] == ch) begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        live_pos = nxt;
        spread_stars();
    endfunction

    function automatic void predict_match(input wgm_pkg::t_in_req req);
        wgm_pkg::t_out_req res;
        case (req.kind)
            wgm_pkg::KIND_PAT_BYTE: begin
                if (glob_closed) begin
                    glob_closed = 1'b0;
                    glob_len    = 0;
                    glob_ovf    = 1'b0;
                end
                if (glob_len < MAX_PATTERN) begin
                    glob_pat[glob_len] = req.byte_value;
                    glob_len++;
                end else begin
                    glob_ovf = 1'b1;
                end
                rewind_candidate();
            end
            wgm_pkg::KIND_PAT_END: begin
                glob_closed = 1'b1;
                rewind_candidate();
            end
            wgm_pkg::KIND_CAND_BYTE: begin
                if (glob_closed) begin
                    step_candidate(req.byte_value);
                end
            end
            default: begin
                if (glob_closed) begin
                    res.matched       = !glob_ovf && live_pos[glob_len];
                    res.pattern_error = glob_ovf;
                    expected_results.push_back(res);
                    rewind_candidate();
                end
            end
        endcase
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_gap > 0) begin
                in_gap--;
                if (in_gap == 0 && $urandom_range(0, 2) == 0) begin
                    in_calm = $urandom_range(20, 150);
                end
                in_valid <= 1'b0;
            end else if (pending_reqs.size() > QUIET_TAIL && in_calm == 0
                         && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(0, 18);
                in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                if (in_calm > 0) begin
                    in_calm--;
                end
                in_valid <= 1'b1;
                in_req   <= pending_reqs.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            if (out_gap == 0 && $urandom_range(0, 2) == 0) begin
                out_calm = $urandom_range(20, 150);
            end
            out_stall <= 1'b1;
        end else if (pending_reqs.size() > QUIET_TAIL && out_calm == 0
                     && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end else begin
            if (out_calm > 0) begin
                out_calm--;
            end
            out_stall <= 1'b0;
        end
    end

    // monitor and scoreboard
    always @(posedge clk) begin
        if (!rst_n) begin
            glob_len     = 0;
            glob_closed  = 1'b1;
            glob_ovf     = 1'b0;
            rewind_candidate();
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (out_valid && !out_stall) begin
                quiet_cycles = 0;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    want_result = expected_results.pop_front();
                    if (out_req.matched !== want_result.matched) begin
                        report_mismatch($sformatf("matched %b, expected %b",
                                        out_req.matched, want_result.matched));
                    end
                    if (out_req.pattern_error !== want_result.pattern_error) begin
                        report_mismatch($sformatf("pattern_error %b, expected %b",
                                        out_req.pattern_error, want_result.pattern_error));
                    end
                end
            end
            if (in_valid && !in_stall) begin
                quiet_cycles = 0;
                predict_match(in_req);
                accepted_count++;
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [7:0] pat_q[$];
        logic [7:0] name_q[$];
        logic [7:0] ch;
        int         plen;
        int         sel;
        int         idx;

        // empty pattern after reset
        push_req(wgm_pkg::KIND_CAND_END, 8'hFF);
        push_req(wgm_pkg::KIND_CAND_BYTE, 8'hFF);
        push_req(wgm_pkg::KIND_CAND_END, 8'h01);
        push_req(wgm_pkg::KIND_PAT_END, 8'h80);
        // names sent while the pattern is open are dropped
        push_req(wgm_pkg::KIND_PAT_BYTE, "a");
        push_req(wgm_pkg::KIND_PAT_BYTE, wgm_pkg::STAR_CHAR);
        push_req(wgm_pkg::KIND_CAND_BYTE, "a");
        push_req(wgm_pkg::KIND_CAND_END, 8'h01);
        push_req(wgm_pkg::KIND_PAT_END, 8'h7F);
        // trailing star
        push_req(wgm_pkg::KIND_CAND_BYTE, "a");
        push_req(wgm_pkg::KIND_CAND_BYTE, 8'hFF);
        push_req(wgm_pkg::KIND_CAND_BYTE, 8'h01);
        push_req(wgm_pkg::KIND_CAND_END, 8'h55);
        // case counts
        push_req(wgm_pkg::KIND_CAND_BYTE, "A");
        push_req(wgm_pkg::KIND_CAND_END, 8'hAA);
        // new pattern drops the name in progress
        push_req(wgm_pkg::KIND_CAND_BYTE, "a");
        push_req(wgm_pkg::KIND_PAT_BYTE, wgm_pkg::ANY_CHAR);
        push_req(wgm_pkg::KIND_PAT_BYTE, 8'hFF);
        push_req(wgm_pkg::KIND_PAT_BYTE, 8'h01);
        push_req(wgm_pkg::KIND_PAT_END, 8'h01);
        push_req(wgm_pkg::KIND_CAND_BYTE, 8'h80);
        push_req(wgm_pkg::KIND_CAND_BYTE, 8'hFF);
        push_req(wgm_pkg::KIND_CAND_BYTE, 8'h01);
        push_req(wgm_pkg::KIND_CAND_END, 8'hFE);
        pat_q = '{wgm_pkg::ANY_CHAR, 8'hFF, 8'h01};

        while (pending_reqs.size() < ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    push_req(wgm_pkg::t_kind'($urandom_range(0, 3)),
                             8'($urandom_range(1, 255)));
                end
                push_req(wgm_pkg::KIND_PAT_END, 8'($urandom_range(1, 255)));
                pat_q.delete();
                pat_q.push_back(wgm_pkg::STAR_CHAR);
                // close with a fresh pattern so the local copy stays in step
                push_req(wgm_pkg::KIND_PAT_BYTE, wgm_pkg::STAR_CHAR);
                push_req(wgm_pkg::KIND_PAT_END, 8'($urandom_range(1, 255)));
            end

            sel = $urandom_range(0, 39);
            if (sel == 0) begin
                plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
            end else if (sel < 3) begin
                plen = $urandom_range(MAX_PATTERN - 8, MAX_PATTERN);
            end else if (sel < 6) begin
                plen = 0;
            end else begin
                plen = $urandom_range(1, 8);
            end

            // zero length keeps the stored pattern
            if (plen > 0) begin
                pat_q.delete();
                for (int i = 0; i < plen; i++) begin
                    case ($urandom_range(0, 9))
                        0, 1:    ch = wgm_pkg::STAR_CHAR;
                        2:       ch = wgm_pkg::ANY_CHAR;
                        3, 4, 5: ch = "a";
                        6, 7, 8: ch = "b";
                        default: ch = 8'($urandom_range(1, 255));
                    endcase
                    if (i < MAX_PATTERN) begin
                        pat_q.push_back(ch);
                    end
                    push_req(wgm_pkg::KIND_PAT_BYTE, ch);
                    if ($urandom_range(0, 29) == 0) begin
                        push_req(wgm_pkg::KIND_CAND_BYTE, name_char());
                    end
                end
            end
            push_req(wgm_pkg::KIND_PAT_END, 8'($urandom_range(1, 255)));

            repeat ($urandom_range(1, 6)) begin
                name_q.delete();
                if ($urandom_range(0, 3) != 0) begin
                    foreach (pat_q[i]) begin
                        if (pat_q[i] == wgm_pkg::STAR_CHAR) begin
                            repeat ($urandom_range(0, 3)) name_q.push_back(name_char());
                        end else if (pat_q[i] == wgm_pkg::ANY_CHAR) begin
                            name_q.push_back(name_char());
                        end else begin
                            name_q.push_back(pat_q[i]);
                        end
                    end
                    sel = $urandom_range(0, 5);
                    if (name_q.size() > 0 && sel == 0) begin
                        idx = $urandom_range(0, name_q.size() - 1);
                        name_q[idx] = name_char();
                    end else if (name_q.size() > 0 && sel == 1) begin
                        idx = $urandom_range(0, name_q.size() - 1);
                        name_q.delete(idx);
                    end else if (sel == 2) begin
                        name_q.push_back(name_char());
                    end
                end else begin
                    repeat ($urandom_range(0, 6)) name_q.push_back(name_char());
                end
                foreach (name_q[i]) begin
                    push_req(wgm_pkg::KIND_CAND_BYTE, name_q[i]);
                end
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    push_req(wgm_pkg::KIND_PAT_END, 8'($urandom_range(1, 255)));
                end else if (sel != 1) begin
                    push_req(wgm_pkg::KIND_CAND_END, 8'($urandom_range(1, 255)));
                end
            end
        end
        total_items = pending_reqs.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
